[rtl/core/tcw_pkg.sv]
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int IN_W       = 48;
  localparam int OUT_W      = 40;
  localparam int USER_W     = 2;
  localparam int POS_W      = 11;
  localparam int BIN_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_W     = $clog2(BIN_W);
  localparam int DIG_W      = $clog2(NUM_DIGITS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] DIGIT_BASE   = 8'h30;

  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_DEC   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic REG_BG_COLOR = 1'b0;
  localparam logic REG_CLEAR_FG = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_direct;
    logic conv_start;
    logic conv_step;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic req_dec;
    logic req_direct;
    logic conv_done;
    logic emit_last;
  } stat_t;

endpackage

[rtl/core/text_console_writer_top.sv]
// Character, newline and clear requests: the result word is registered on acceptance,
// and one such request is taken per cycle while the output is drained.
// Decimal requests: after acceptance a shift-and-add-3 BCD converter takes in all 32
// value bits, a scan state finds the top nonzero digit, and the digits are then emitted
// most significant first, each when the output is free; no new request is taken meanwhile.
// Reset is synchronous and active high: it empties the output, homes the cursor and
// sets the background to 0 and the clear foreground to 15.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [3:0]                 cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // req_type[1:0], char_code[9:2], value[41:10], color[45:42], zero pad[47:46]
  input  logic [tcw_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // cell_index[10:0], char_out[18:11], attribute[26:19], cursor_pos[37:27],
  // string_done[38], zero pad[39]
  output logic [tcw_pkg::OUT_W-1:0]  m_tdata,
  // write_valid[0], clear_screen[1]
  output logic [tcw_pkg::USER_W-1:0] m_tuser,
  output logic                       m_tlast
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::stat_t stat;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/core/tcw_ctrl.sv]
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  tcw_pkg::stat_t stat,
  output tcw_pkg::cmd_t  cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;
  logic            out_free;
  logic            m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::S_IDLE: begin
        if (s_tvalid && out_free && stat.req_dec) state_next = tcw_pkg::S_CONV;
      end
      tcw_pkg::S_CONV: begin
        if (stat.conv_done) state_next = tcw_pkg::S_SCAN;
      end
      tcw_pkg::S_SCAN: state_next = tcw_pkg::S_EMIT;
      tcw_pkg::S_EMIT: begin
        if (out_free && stat.emit_last) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      tcw_pkg::S_IDLE: begin
        s_tready        = out_free;
        cmd.load_direct = s_tvalid && out_free && stat.req_direct;
        cmd.conv_start  = s_tvalid && out_free && stat.req_dec;
      end
      tcw_pkg::S_CONV: cmd.conv_step = 1'b1;
      tcw_pkg::S_SCAN: cmd.scan = 1'b1;
      tcw_pkg::S_EMIT: cmd.emit = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_direct || cmd.emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

[rtl/core/tcw_dp.sv]
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [3:0]                   cfg_data,
  input  logic [tcw_pkg::IN_W-1:0]     s_tdata,
  input  logic                         s_tlast,
  output logic [tcw_pkg::OUT_W-1:0]    m_tdata,
  output logic [tcw_pkg::USER_W-1:0]   m_tuser,
  output logic                         m_tlast,
  input  tcw_pkg::cmd_t                cmd,
  output tcw_pkg::stat_t               stat
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CUR_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLUMNS + 1);

  logic [1:0]                  in_type;
  logic [7:0]                  in_char;
  logic [tcw_pkg::BIN_W-1:0]   in_value;
  logic [3:0]                  in_color;

  logic [CUR_W-1:0]            cursor;
  logic [COL_W-1:0]            col;
  logic [3:0]                  bg_color;
  logic [3:0]                  clear_fg;

  logic [3:0]                  dec_color;
  logic                        dec_send;
  logic [tcw_pkg::BIN_W-1:0]   bin;
  logic [tcw_pkg::BCD_W-1:0]   bcd;
  logic [tcw_pkg::BCD_W-1:0]   bcd_adj;
  logic [tcw_pkg::STEP_W-1:0]  step;
  logic [tcw_pkg::DIG_W-1:0]   dig_idx;
  logic [tcw_pkg::DIG_W-1:0]   top_idx;
  logic [3:0]                  digit;

  logic [7:0]                  ch_sel;
  logic [3:0]                  fg_sel;
  logic                        send_sel;
  logic                        last_sel;
  logic                        is_nl;
  logic [CUR_W-1:0]            nl_cursor;
  logic [CUR_W-1:0]            inc_cursor;
  logic [CUR_W-1:0]            cursor_next;
  logic [COL_W-1:0]            col_next;
  logic [31:0]                 cur_wide;
  logic [31:0]                 next_wide;
  logic                        is_clear;

  assign in_type  = s_tdata[1:0];
  assign in_char  = s_tdata[9:2];
  assign in_value = s_tdata[41:10];
  assign in_color = s_tdata[45:42];

  assign stat.req_dec    = in_type == tcw_pkg::REQ_DEC;
  assign stat.req_direct = (in_type == tcw_pkg::REQ_CHAR) || (in_type == tcw_pkg::REQ_CLEAR);
  assign stat.conv_done  = step == tcw_pkg::STEP_W'(tcw_pkg::BIN_W - 1);
  assign stat.emit_last  = dig_idx == '0;

  assign is_clear = in_type == tcw_pkg::REQ_CLEAR;

  always_comb begin
    for (int i = 0; i < tcw_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < tcw_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) top_idx = tcw_pkg::DIG_W'(i);
    end
  end

  assign digit = bcd[{dig_idx, 2'b00} +: 4];

  always_comb begin
    if (cmd.emit) begin
      ch_sel   = tcw_pkg::DIGIT_BASE + {4'd0, digit};
      fg_sel   = dec_color;
      last_sel = dig_idx == '0;
      send_sel = (dig_idx == '0) && dec_send;
    end else begin
      ch_sel   = in_char;
      fg_sel   = in_color;
      last_sel = 1'b1;
      send_sel = s_tlast;
    end
  end

  assign is_nl      = ch_sel == tcw_pkg::NEWLINE_CODE;
  assign nl_cursor  = cursor - CUR_W'(col) + CUR_W'(COLUMNS);
  assign inc_cursor = cursor + CUR_W'(1);

  always_comb begin
    if (is_nl) begin
      col_next = '0;
      if (nl_cursor >= CUR_W'(CELLS)) begin
        cursor_next = '0;
      end else begin
        cursor_next = nl_cursor;
      end
    end else if (inc_cursor == CUR_W'(CELLS)) begin
      cursor_next = '0;
      col_next    = '0;
    end else begin
      cursor_next = inc_cursor;
      if (col == COL_W'(COLUMNS - 1)) begin
        col_next = '0;
      end else begin
        col_next = col + COL_W'(1);
      end
    end
  end

  assign cur_wide  = 32'(cursor);
  assign next_wide = 32'(cursor_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      col      <= '0;
      bg_color <= 4'd0;
      clear_fg <= 4'd15;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::REG_BG_COLOR: bg_color <= cfg_data;
          tcw_pkg::REG_CLEAR_FG: clear_fg <= cfg_data;
          default: bg_color <= bg_color;
        endcase
      end
      if (cmd.load_direct && is_clear) begin
        cursor <= '0;
        col    <= '0;
      end else if (cmd.load_direct || cmd.emit) begin
        cursor <= cursor_next;
        col    <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_start) begin
      bin       <= in_value;
      bcd       <= '0;
      step      <= '0;
      dec_color <= in_color;
      dec_send  <= s_tlast;
    end else if (cmd.conv_step) begin
      bcd  <= {bcd_adj[tcw_pkg::BCD_W-2:0], bin[tcw_pkg::BIN_W-1]};
      bin  <= {bin[tcw_pkg::BIN_W-2:0], 1'b0};
      step <= step + tcw_pkg::STEP_W'(1);
    end
    if (cmd.scan) begin
      dig_idx <= top_idx;
    end else if (cmd.emit) begin
      dig_idx <= dig_idx - tcw_pkg::DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_direct && is_clear) begin
      m_tdata <= {1'b0, 1'b0, tcw_pkg::POS_W'(0), clear_fg, bg_color,
                  tcw_pkg::SPACE_CODE, tcw_pkg::POS_W'(0)};
      m_tuser <= 2'b10;
      m_tlast <= 1'b1;
    end else if (cmd.load_direct || cmd.emit) begin
      if (is_nl) begin
        m_tdata <= {1'b0, send_sel, next_wide[tcw_pkg::POS_W-1:0], 8'd0, 8'd0,
                    tcw_pkg::POS_W'(0)};
        m_tuser <= 2'b00;
      end else begin
        m_tdata <= {1'b0, send_sel, next_wide[tcw_pkg::POS_W-1:0], fg_sel, bg_color,
                    ch_sel, cur_wide[tcw_pkg::POS_W-1:0]};
        m_tuser <= 2'b01;
      end
      m_tlast <= last_sel;
    end
  end

endmodule

[rtl/core/tcw_checker.sv]
module tcw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tcw_pkg::OUT_W-1:0]  m_tdata,
  input logic [tcw_pkg::USER_W-1:0] m_tuser,
  input logic                       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input taken while output register is full");

  a_clear_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tlast && m_tdata[37:27] == 11'd0
      && m_tdata[38] == 1'b0)
    else $error("clear word malformed");

  a_newline_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[26:0] == 27'd0)
    else $error("newline word carries cell data");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[38] |-> m_tlast)
    else $error("string done flagged on a word that is not last");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[tb/tb_text_console_writer_top.sv]
module tb_text_console_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int CELLS = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 130;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic [31:0] val;
    logic [3:0]  fg;
    logic        send_end;
  } req_t;

  typedef struct packed {
    logic        wv;
    logic [10:0] cell_idx;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [10:0] cur;
    logic        clr;
    logic        done;
    logic        lst;
  } cell_wr_t;

  typedef struct {
    req_t     rq;
    bit       typed;
    cell_wr_t want;
  } row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [3:0]                 cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [tcw_pkg::IN_W-1:0]   s_tdata;
  logic                       s_tlast;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [tcw_pkg::OUT_W-1:0]  m_tdata;
  logic [tcw_pkg::USER_W-1:0] m_tuser;
  logic                       m_tlast;

  text_console_writer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Console state as the testbench sees it.
  logic [10:0] cursor_cell;
  logic [3:0]  bg_nib;
  logic [3:0]  clear_nib;

  cell_wr_t expected_cells[$];
  int       error_count;
  int       burst_left;
  int       stall_mode;
  int       stall_left;
  int       stall_tick;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic string cell_str(cell_wr_t c);
    return $sformatf("wv=%0d cell=%0d ch=%02h attr=%02h cur=%0d clr=%0d done=%0d last=%0d",
                     c.wv, c.cell_idx, c.ch, c.attr, c.cur, c.clr, c.done, c.lst);
  endfunction

  task automatic note_failure(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic put_glyph(input logic [7:0] code, input logic [3:0] fg, input logic done,
                           input logic lst, ref cell_wr_t cells[$]);
    cell_wr_t c;
    int       next;
    c = '0;
    if (code == tcw_pkg::NEWLINE_CODE) begin
      next = (int'(cursor_cell) / COLS + 1) * COLS;
    end else begin
      c.wv       = 1'b1;
      c.cell_idx = cursor_cell;
      c.ch       = code;
      c.attr     = {fg, bg_nib};
      next       = int'(cursor_cell) + 1;
    end
    if (next >= CELLS) begin
      next = 0;
    end
    cursor_cell = next[10:0];
    c.cur  = cursor_cell;
    c.done = done;
    c.lst  = lst;
    cells.push_back(c);
  endtask

  task automatic predict_cells(input req_t rq, ref cell_wr_t cells[$]);
    logic [3:0]  digits[tcw_pkg::NUM_DIGITS];
    logic [31:0] v;
    int          n;
    cell_wr_t    c;
    case (rq.kind)
      tcw_pkg::REQ_CHAR: begin
        put_glyph(rq.code, rq.fg, rq.send_end, 1'b1, cells);
      end
      tcw_pkg::REQ_DEC: begin
        v = rq.val;
        n = 0;
        do begin
          digits[n] = 4'(v % 10);
          v = v / 10;
          n++;
        end while (v != 0 && n < tcw_pkg::NUM_DIGITS);
        for (int i = 0; i < n; i++) begin
          put_glyph(tcw_pkg::DIGIT_BASE + 8'(digits[n - 1 - i]), rq.fg,
                    (i == n - 1) ? rq.send_end : 1'b0, i == n - 1, cells);
        end
      end
      tcw_pkg::REQ_CLEAR: begin
        cursor_cell = '0;
        c = '0;
        c.ch   = tcw_pkg::SPACE_CODE;
        c.attr = {clear_nib, bg_nib};
        c.clr  = 1'b1;
        c.lst  = 1'b1;
        cells.push_back(c);
      end
      default: ;
    endcase
  endtask

  function automatic req_t mk_req(logic [1:0] kind, logic [7:0] code, logic [31:0] val,
                                  logic [3:0] fg, logic send_end);
    req_t r;
    r.kind     = kind;
    r.code     = code;
    r.val      = val;
    r.fg       = fg;
    r.send_end = send_end;
    return r;
  endfunction

  function automatic cell_wr_t mk_cell(logic wv, logic [10:0] cell_idx, logic [7:0] ch,
                                       logic [7:0] attr, logic [10:0] cur, logic clr,
                                       logic done);
    cell_wr_t c;
    c.wv       = wv;
    c.cell_idx = cell_idx;
    c.ch       = ch;
    c.attr     = attr;
    c.cur      = cur;
    c.clr      = clr;
    c.done     = done;
    c.lst      = 1'b1;
    return c;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   pick;
    r.code     = 8'($urandom_range(0, 255));
    r.val      = $urandom;
    r.fg       = 4'($urandom_range(0, 15));
    r.send_end = ($urandom_range(0, 5) == 0);
    pick       = $urandom_range(0, 99);
    if (pick < 55) begin
      r.kind = tcw_pkg::REQ_CHAR;
    end else if (pick < 66) begin
      r.kind = tcw_pkg::REQ_CHAR;
      r.code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 92) begin
      r.kind = tcw_pkg::REQ_DEC;
      case ($urandom_range(0, 3))
        0: r.val = $urandom_range(0, 99);
        1: r.val = r.val >> $urandom_range(0, 31);
        default: ;
      endcase
    end else if (pick < 96) begin
      r.kind = tcw_pkg::REQ_CLEAR;
    end else begin
      r.kind = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send_word(input req_t rq);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, rq.fg, rq.val, rq.code, rq.kind};
    s_tlast  <= rq.send_end;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic apply(input req_t rq, input bit typed, input cell_wr_t want);
    cell_wr_t cells[$];
    send_word(rq);
    predict_cells(rq, cells);
    if (typed) begin
      expected_cells.push_back(want);
    end else begin
      foreach (cells[i]) expected_cells.push_back(cells[i]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == tcw_pkg::REG_BG_COLOR) begin
      bg_nib = val;
    end else begin
      clear_nib = val;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int count);
    req_t rq;
    int   done_items;
    done_items = 0;
    while (done_items < count) begin
      rq = rand_req();
      apply(rq, 1'b0, '0);
      if (rq.kind != REQ_UNUSED) begin
        done_items++;
      end
    end
  endtask

  // Receiver readiness follows a randomly chosen mode that is picked anew at random intervals.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= (stall_tick % 4 == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    cell_wr_t got;
    cell_wr_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.wv       = m_tuser[0];
      got.clr      = m_tuser[1];
      got.cell_idx = m_tdata[10:0];
      got.ch       = m_tdata[18:11];
      got.attr     = m_tdata[26:19];
      got.cur      = m_tdata[37:27];
      got.done     = m_tdata[38];
      got.lst      = m_tlast;
      if (expected_cells.size() == 0) begin
        note_failure({"unexpected word: ", cell_str(got)});
      end else begin
        want = expected_cells.pop_front();
        if (got.wv !== want.wv || got.cell_idx !== want.cell_idx || got.ch !== want.ch ||
            got.attr !== want.attr || got.cur !== want.cur || got.clr !== want.clr ||
            got.done !== want.done || got.lst !== want.lst) begin
          note_failure({"mismatch expected ", cell_str(want), " got ", cell_str(got)});
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t rows[$];
    req_t rq;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = 1'b0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    m_tready    = 1'b0;
    cursor_cell = '0;
    bg_nib      = 4'h0;
    clear_nib   = 4'hF;
    error_count = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_left  = 0;
    stall_tick  = 0;

    // Directed rows run with the reset colors.
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, 8'h41, 32'h0, 4'hF, 1'b0), 1'b1,
                     mk_cell(1'b1, 11'd0, 8'h41, 8'hF0, 11'd1, 1'b0, 1'b0)});
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, tcw_pkg::NEWLINE_CODE, 32'hFFFF_FFFF,
                            4'h3, 1'b1), 1'b1,
                     mk_cell(1'b0, 11'd0, 8'h00, 8'h00, 11'd80, 1'b0, 1'b1)});
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, 8'hFF, 32'h0, 4'h0, 1'b1), 1'b1,
                     mk_cell(1'b1, 11'd80, 8'hFF, 8'h00, 11'd81, 1'b0, 1'b1)});
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, 8'h00, 32'hFFFF_FFFF, 4'hF, 1'b0), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'hFF, 32'd0, 4'h5, 1'b1), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h00, 32'hFFFF_FFFF, 4'hA, 1'b1), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h0A, 32'd9, 4'h1, 1'b0), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h00, 32'd10, 4'h2, 1'b1), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h00, 32'd1_000_000_000, 4'hF, 1'b0),
                     1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h00, 32'd999_999_999, 4'h0, 1'b1),
                     1'b0, '0});
    rows.push_back('{mk_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 4'hF, 1'b1), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, tcw_pkg::NEWLINE_CODE, 32'h0, 4'hF, 1'b0),
                     1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_CLEAR, 8'h41, 32'hFFFF_FFFF, 4'h7, 1'b1), 1'b1,
                     mk_cell(1'b0, 11'd0, tcw_pkg::SPACE_CODE, 8'hF0, 11'd0, 1'b1, 1'b0)});
    rows.push_back('{mk_req(tcw_pkg::REQ_CHAR, tcw_pkg::SPACE_CODE, 32'h0, 4'h1, 1'b0), 1'b1,
                     mk_cell(1'b1, 11'd0, tcw_pkg::SPACE_CODE, 8'h10, 11'd1, 1'b0, 1'b0)});
    rows.push_back('{mk_req(REQ_UNUSED, 8'h00, 32'h0, 4'h0, 1'b0), 1'b0, '0});
    rows.push_back('{mk_req(tcw_pkg::REQ_DEC, 8'h00, 32'd7, 4'h8, 1'b1), 1'b0, '0});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) apply(rows[i].rq, rows[i].typed, rows[i].want);
    drain();

    // Extreme colors, then walk the cursor to the bottom row and wrap it twice:
    // once through written digits and once through a newline.
    write_reg(tcw_pkg::REG_BG_COLOR, 4'hF);
    write_reg(tcw_pkg::REG_CLEAR_FG, 4'h0);
    apply(mk_req(tcw_pkg::REQ_CLEAR, 8'($urandom), $urandom, 4'($urandom), 1'b0), 1'b0, '0);
    repeat (tcw_pkg::ROWS_DEF - 1) begin
      apply(mk_req(tcw_pkg::REQ_CHAR, tcw_pkg::NEWLINE_CODE, $urandom, 4'($urandom),
                   1'($urandom)), 1'b0, '0);
    end
    repeat (COLS / tcw_pkg::NUM_DIGITS) begin
      rq = mk_req(tcw_pkg::REQ_DEC, 8'($urandom),
                  32'($urandom_range(32'hFFFF_FFFF, 1_000_000_000)),
                  4'($urandom), 1'($urandom));
      apply(rq, 1'b0, '0);
    end
    repeat (tcw_pkg::ROWS_DEF) begin
      apply(mk_req(tcw_pkg::REQ_CHAR, tcw_pkg::NEWLINE_CODE, $urandom, 4'($urandom),
                   1'($urandom)), 1'b0, '0);
    end
    random_run(RANDOM_PER_PHASE);
    drain();

    write_reg(tcw_pkg::REG_BG_COLOR, 4'h0);
    write_reg(tcw_pkg::REG_CLEAR_FG, 4'($urandom));
    random_run(RANDOM_PER_PHASE);
    drain();

    write_reg(tcw_pkg::REG_CLEAR_FG, 4'hF);
    write_reg(tcw_pkg::REG_BG_COLOR, 4'($urandom));
    random_run(RANDOM_PER_PHASE);
    drain();

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dp.sv
rtl/core/text_console_writer_top.sv
rtl/core/tcw_checker.sv
tb/tb_text_console_writer_top.sv
